### rtl/esc_pkg.sv
`default_nettype none

package esc_pkg;

  localparam int REM_W       = 17;
  localparam int DAY_SECS    = 86400;
  // 86400 = 675 << 7
  localparam int DAY_SHIFT   = 7;
  localparam int DAY_ODD     = 675;
  localparam int HOUR_SECS   = 3600;
  localparam int MIN_SECS    = 60;
  localparam int DAYS_400Y   = 146097;
  localparam int DAYS_100Y   = 36524;
  localparam int DAYS_4Y     = 1461;
  localparam int DAYS_1Y     = 365;
  localparam int YEAR_DAYS_MAX = 366;
  // days from 1601-01-01 to 1970-01-01
  localparam int REBASE_DAYS = 134774;
  localparam int BASE_YEAR   = 1601;
  localparam int CENT_MAX    = 3;
  localparam int QUAD_MAX    = 24;
  localparam int YEAR_MAX    = 3;
  localparam int MONTHS      = 12;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV,
    OP_REBASE,
    OP_Y400,
    OP_Y100,
    OP_Y4,
    OP_Y1,
    OP_MON,
    OP_HOUR,
    OP_MIN,
    OP_OUT
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_REBASE,
    S_Y400,
    S_Y100,
    S_Y4,
    S_Y1,
    S_MON,
    S_HOUR,
    S_MIN,
    S_OUT
  } state_t;

  typedef struct packed {
    logic div_last;
    logic y400;
    logic y100;
    logic y4;
    logic y1;
    logic mon;
    logic hour;
    logic minute;
  } sts_t;

  function automatic logic [4:0] month_days(input logic [3:0] mo, input logic leap);
    logic [4:0] n;
    case (mo) inside
      4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
      4'd2:                    n = leap ? 5'd29 : 5'd28;
      default:                 n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

### rtl/esc_ctrl.sv
`default_nettype none

module esc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  input  wire esc_pkg::sts_t sts,
  output esc_pkg::op_t       op
);

  esc_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= esc_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    op            = esc_pkg::OP_NONE;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      esc_pkg::S_IDLE: begin
        if (in_tvalid) begin
          op        = esc_pkg::OP_LOAD;
          state_nxt = esc_pkg::S_DIV;
        end
      end
      esc_pkg::S_DIV: begin
        op = esc_pkg::OP_DIV;
        if (sts.div_last) state_nxt = esc_pkg::S_REBASE;
      end
      esc_pkg::S_REBASE: begin
        op        = esc_pkg::OP_REBASE;
        state_nxt = esc_pkg::S_Y400;
      end
      esc_pkg::S_Y400: begin
        if (sts.y400) op = esc_pkg::OP_Y400;
        else state_nxt = esc_pkg::S_Y100;
      end
      esc_pkg::S_Y100: begin
        if (sts.y100) op = esc_pkg::OP_Y100;
        else state_nxt = esc_pkg::S_Y4;
      end
      esc_pkg::S_Y4: begin
        if (sts.y4) op = esc_pkg::OP_Y4;
        else state_nxt = esc_pkg::S_Y1;
      end
      esc_pkg::S_Y1: begin
        if (sts.y1) op = esc_pkg::OP_Y1;
        else state_nxt = esc_pkg::S_MON;
      end
      esc_pkg::S_MON: begin
        if (sts.mon) op = esc_pkg::OP_MON;
        else state_nxt = esc_pkg::S_HOUR;
      end
      esc_pkg::S_HOUR: begin
        if (sts.hour) op = esc_pkg::OP_HOUR;
        else state_nxt = esc_pkg::S_MIN;
      end
      esc_pkg::S_MIN: begin
        if (sts.minute) op = esc_pkg::OP_MIN;
        else state_nxt = esc_pkg::S_OUT;
      end
      esc_pkg::S_OUT: begin
        if (!out_valid_r || out_tready) begin
          op            = esc_pkg::OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = esc_pkg::S_IDLE;
        end
      end
      default: state_nxt = esc_pkg::S_IDLE;
    endcase
  end

  assign in_tready  = (state_r == esc_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == esc_pkg::S_OUT && out_valid_r && !out_tready) |=>
      (state_r == esc_pkg::S_OUT && out_valid_r))
    else $error("result overwritten while waiting");

  a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (op == esc_pkg::OP_LOAD) |=> (state_r == esc_pkg::S_DIV))
    else $error("load did not start division");

endmodule

`default_nettype wire

### rtl/esc_dp.sv
`default_nettype none

module esc_dp #(
  parameter int SECONDS_BITS = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire esc_pkg::op_t            op,
  input  wire logic [SECONDS_BITS-1:0] seconds,
  output esc_pkg::sts_t                sts,
  output logic [11:0]                  year_out,
  output logic [3:0]                   month_out,
  output logic [4:0]                   day_out,
  output logic [4:0]                   hour_out,
  output logic [5:0]                   minute_out,
  output logic [5:0]                   second_out
);

  localparam int DAY_W  = SECONDS_BITS - 16;
  localparam int X_W    = SECONDS_BITS - esc_pkg::DAY_SHIFT;
  localparam int MUL_W  = X_W + DAY_W;
  localparam int DW     = DAY_W + 2;
  localparam int YEAR_W = (DW - 8 > 11) ? DW - 7 : 12;
  localparam int CNT_W  = 2;
  localparam int REM_W  = esc_pkg::REM_W;
  localparam int PART_W = REM_W - esc_pkg::DAY_SHIFT;
  // floor(2**X_W / 675): the quotient estimate is low by at most one
  localparam longint unsigned RECIP = (64'd1 << X_W) / esc_pkg::DAY_ODD;
  localparam logic [CNT_W-1:0] DIV_MUL  = 2'd0;
  localparam logic [CNT_W-1:0] DIV_PROD = 2'd1;
  localparam logic [CNT_W-1:0] DIV_FIX  = 2'd2;

  logic [SECONDS_BITS-1:0] num_r;
  logic [REM_W-1:0]        rem_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [DAY_W-1:0]        q_r;
  logic [X_W-1:0]          prod_r;
  logic [DW-1:0]           days_r;
  logic [YEAR_W-1:0]       year_r;
  logic [1:0]              q100_r;
  logic [4:0]              q4_r;
  logic [1:0]              q1_r;
  logic [3:0]              mo_r;
  logic [4:0]              hr_r;
  logic [5:0]              min_r;

  logic [MUL_W-1:0]        mul;
  logic [X_W-1:0]          diff;
  logic                    fix;
  logic [PART_W-1:0]       part;
  logic                    leap;
  logic [4:0]              dim;

  assign mul    = MUL_W'(num_r[SECONDS_BITS-1:esc_pkg::DAY_SHIFT]) * MUL_W'(RECIP);
  assign diff   = num_r[SECONDS_BITS-1:esc_pkg::DAY_SHIFT] - prod_r;
  assign fix    = diff >= X_W'(esc_pkg::DAY_ODD);
  assign part   = PART_W'(fix ? diff - X_W'(esc_pkg::DAY_ODD) : diff);
  assign leap   = (q1_r == 2'(esc_pkg::YEAR_MAX)) &&
                  ((q4_r != 5'(esc_pkg::QUAD_MAX)) || (q100_r == 2'(esc_pkg::CENT_MAX)));
  assign dim    = esc_pkg::month_days(mo_r, leap);

  always_comb begin
    sts.div_last = (cnt_r == DIV_FIX);
    sts.y400     = days_r >= DW'(esc_pkg::DAYS_400Y);
    sts.y100     = (days_r >= DW'(esc_pkg::DAYS_100Y)) && (q100_r != 2'(esc_pkg::CENT_MAX));
    sts.y4       = (days_r >= DW'(esc_pkg::DAYS_4Y)) && (q4_r != 5'(esc_pkg::QUAD_MAX));
    sts.y1       = (days_r >= DW'(esc_pkg::DAYS_1Y)) && (q1_r != 2'(esc_pkg::YEAR_MAX));
    sts.mon      = (mo_r < 4'(esc_pkg::MONTHS)) && (days_r >= DW'(dim));
    sts.hour     = rem_r >= REM_W'(esc_pkg::HOUR_SECS);
    sts.minute   = rem_r >= REM_W'(esc_pkg::MIN_SECS);
  end

  always_ff @(posedge clk) begin
    case (op)
      esc_pkg::OP_LOAD: begin
        num_r <= seconds;
        rem_r <= '0;
        cnt_r <= '0;
        mo_r  <= 4'd1;
        hr_r  <= '0;
        min_r <= '0;
      end
      esc_pkg::OP_DIV: begin
        case (cnt_r)
          DIV_MUL:  q_r    <= DAY_W'(mul >> X_W);
          DIV_PROD: prod_r <= X_W'(q_r) * X_W'(esc_pkg::DAY_ODD);
          DIV_FIX: begin
            q_r   <= q_r + DAY_W'(fix);
            rem_r <= {part, num_r[esc_pkg::DAY_SHIFT-1:0]};
          end
          default: ;
        endcase
        cnt_r <= cnt_r + 1'b1;
      end
      esc_pkg::OP_REBASE: begin
        days_r <= DW'(q_r) + DW'(esc_pkg::REBASE_DAYS);
        year_r <= YEAR_W'(esc_pkg::BASE_YEAR);
        q100_r <= '0;
        q4_r   <= '0;
        q1_r   <= '0;
      end
      esc_pkg::OP_Y400: begin
        days_r <= days_r - DW'(esc_pkg::DAYS_400Y);
        year_r <= year_r + YEAR_W'(400);
      end
      esc_pkg::OP_Y100: begin
        days_r <= days_r - DW'(esc_pkg::DAYS_100Y);
        year_r <= year_r + YEAR_W'(100);
        q100_r <= q100_r + 1'b1;
      end
      esc_pkg::OP_Y4: begin
        days_r <= days_r - DW'(esc_pkg::DAYS_4Y);
        year_r <= year_r + YEAR_W'(4);
        q4_r   <= q4_r + 1'b1;
      end
      esc_pkg::OP_Y1: begin
        days_r <= days_r - DW'(esc_pkg::DAYS_1Y);
        year_r <= year_r + YEAR_W'(1);
        q1_r   <= q1_r + 1'b1;
      end
      esc_pkg::OP_MON: begin
        days_r <= days_r - DW'(dim);
        mo_r   <= mo_r + 1'b1;
      end
      esc_pkg::OP_HOUR: begin
        rem_r <= rem_r - REM_W'(esc_pkg::HOUR_SECS);
        hr_r  <= hr_r + 1'b1;
      end
      esc_pkg::OP_MIN: begin
        rem_r <= rem_r - REM_W'(esc_pkg::MIN_SECS);
        min_r <= min_r + 1'b1;
      end
      esc_pkg::OP_OUT: begin
        year_out   <= year_r[11:0];
        month_out  <= mo_r;
        day_out    <= days_r[4:0] + 5'd1;
        hour_out   <= hr_r;
        minute_out <= min_r;
        second_out <= rem_r[5:0];
      end
      default: ;
    endcase
  end

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (op == esc_pkg::OP_DIV) |=> (rem_r < REM_W'(esc_pkg::DAY_SECS)))
    else $error("division remainder out of range");

  a_year_done: assert property (@(posedge clk) disable iff (!rst_n)
    (op == esc_pkg::OP_MON) |-> (days_r < DW'(esc_pkg::YEAR_DAYS_MAX)))
    else $error("day count too large after year reduction");

  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    (op == esc_pkg::OP_OUT) |=> (month_out != 4'd0 && month_out <= 4'(esc_pkg::MONTHS)))
    else $error("month out of range");

endmodule

`default_nettype wire

### rtl/epoch_seconds_to_calendar.sv
`default_nettype none

// Converts Unix seconds to Gregorian UTC year, month, day, hour, minute and second.
// One transaction in gives one transaction out. From input acceptance to output valid a
// conversion does the divide by 86400 (reciprocal multiply by 1/675, then one
// correction step), rebases the day count to 1601, runs seven compare-subtract loops
// and loads the output register. The loops take 400-year blocks (0..1 at 32 bits),
// then at most 3 centuries, 24 four-year groups, 3 years, 11 months, 23 hours and
// 59 minutes. A new input is taken once the previous result sits in the output
// register, even if not yet taken; the next result then waits until the output
// register is free.

module epoch_seconds_to_calendar #(
  parameter int SECONDS_BITS = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // [SECONDS_BITS-1:0] epoch_seconds
  input  wire logic [((SECONDS_BITS+7)/8)*8-1:0]   in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [11:0] year_out, [15:12] month_out, [20:16] day_out, [25:21] hour_out,
  // [31:26] minute_out, [37:32] second_out
  output logic [39:0]                              out_tdata
);

  esc_pkg::sts_t sts;
  esc_pkg::op_t  op;
  logic [11:0]   year_out;
  logic [3:0]    month_out;
  logic [4:0]    day_out;
  logic [4:0]    hour_out;
  logic [5:0]    minute_out;
  logic [5:0]    second_out;

  esc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .op         (op)
  );

  esc_dp #(
    .SECONDS_BITS (SECONDS_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (op),
    .seconds    (in_tdata[SECONDS_BITS-1:0]),
    .sts        (sts),
    .year_out   (year_out),
    .month_out  (month_out),
    .day_out    (day_out),
    .hour_out   (hour_out),
    .minute_out (minute_out),
    .second_out (second_out)
  );

  assign out_tdata = {2'b00, second_out, minute_out, hour_out, day_out, month_out, year_out};

endmodule

`default_nettype wire
